@@ hw/rtl/tteq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tteq_pkg;

   // Queue geometry, shared by the three byte queues
   localparam int QUEUE_DEPTH = 8;
   localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam int BYTE_W      = 8;
   localparam int ACTION_W    = 2;
   localparam int RSP_W       = 24;

   // Action codes carried on req_tuser
   localparam logic [ACTION_W-1:0] ACT_RX_BYTE  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_TX_READY = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_HOST_WR  = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_HOST_RD  = 2'd3;

   // Per-queue command: push with data, pop from head
   typedef struct packed {
      logic              push;
      logic [BYTE_W-1:0] push_data;
      logic              pop;
   } fifo_cmd_type;

   // Flags of an item waiting for its read data
   typedef struct packed {
      logic tx_valid;
      logic tx_from_echo;
      logic read_valid;
      logic write_accepted;
      logic tx_irq_enable;
      logic wake_writer;
      logic rx_dropped;
   } pend_type;

endpackage

`default_nettype wire

@@ hw/rtl/tteq_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tteq_fifo
   import tteq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fifo_cmd_type       cmd,
   output logic [CNT_W-1:0]        count,
   output logic [BYTE_W-1:0]       rd_data
);

   localparam int SUM_W = CNT_W + 1;

   logic [BYTE_W-1:0] mem [QUEUE_DEPTH];
   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic [SUM_W-1:0]  wr_sum;
   logic [SUM_W-1:0]  wr_wrap;
   logic [PTR_W-1:0]  wr_addr;

   // Tail slot: head + count, folded once into range
   always_comb begin
      wr_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
      wr_wrap = (wr_sum >= SUM_W'(QUEUE_DEPTH)) ? (wr_sum - SUM_W'(QUEUE_DEPTH)) : wr_sum;
      wr_addr = wr_wrap[PTR_W-1:0];
   end

   // Pointer and fill count; caller only pushes when not full, pops when not empty
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.pop) begin
         head_in = (head_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
      end
      unique case ({cmd.push, cmd.pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[wr_addr] <= cmd.push_data;
      end
      if (cmd.pop) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   assign count   = count_ff;
   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/tty_echo_tx_rx_queue_engine_top.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Terminal line buffer with echo: receive, echo and transmit byte queues.
// Request channel (req_): one beat per event; req_tuser gives the action
// (byte received, transmitter ready, host write, host read), req_tdata the byte.
// Response channel (rsp_): exactly one beat per request, in order, carrying
// the transmit byte, host read byte and status flags.
// Config port (csr_): csr_we writes echo enable from csr_wdata; write only
// while no request is in flight.
// Pipeline: a response passes the read stage, where the queue memory is
// read, then the output register. Throughput: one request per cycle while
// the output does not stall; each queue memory has one write and one read
// port, and each action needs at most one access per queue.
// Reset: all queues empty, transmit interrupt off, echo enabled; the
// queue storage itself is not cleared, entries are read only once written.
// Stall: if rsp_tready is low, the output register holds its beat, one
// further result waits in the read stage, and then req_tready drops.
module tty_echo_tx_rx_queue_engine_top
   import tteq_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   // request
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [BYTE_W-1:0]   req_tdata,   // [7:0] data_byte
   input  wire logic [ACTION_W-1:0] req_tuser,   // [1:0] action
   // response
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   // [0] tx_valid, [8:1] tx_byte, [9] read_valid, [17:10] read_byte,
   // [18] write_accepted, [19] tx_irq_enable, [20] wake_writer,
   // [21] rx_dropped, [23:22] zero
   output logic [RSP_W-1:0]         rsp_tdata,
   // configuration
   input  wire logic                csr_we,
   input  wire logic                csr_wdata
);

   fifo_cmd_type      rx_cmd, echo_cmd, tx_cmd;
   logic [CNT_W-1:0]  rx_count, echo_count, tx_count;
   logic [BYTE_W-1:0] rx_rd, echo_rd, tx_rd;

   logic              echo_en_ff;
   logic              irq_ff, irq_in;
   logic              pend_vld_ff, pend_vld_in;
   pend_type          pend_ff, pend_in;
   logic              rsp_vld_ff, rsp_vld_in;
   logic [RSP_W-1:0]  rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              out_free;
   logic              move;
   logic              rx_full, echo_full, tx_full;
   logic              echo_empty, tx_empty, rx_empty;
   logic [BYTE_W-1:0] tx_byte, rd_byte;

   assign rx_full    = (rx_count == CNT_W'(QUEUE_DEPTH));
   assign echo_full  = (echo_count == CNT_W'(QUEUE_DEPTH));
   assign tx_full    = (tx_count == CNT_W'(QUEUE_DEPTH));
   assign rx_empty   = (rx_count == '0);
   assign echo_empty = (echo_count == '0);
   assign tx_empty   = (tx_count == '0);

   // Handshake: output slot frees when empty or being taken
   assign out_free   = !rsp_vld_ff || rsp_tready;
   assign move       = pend_vld_ff && out_free;
   assign req_tready = !pend_vld_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   // Decode the action into queue commands and result flags
   always_comb begin
      rx_cmd   = '{push: 1'b0, push_data: req_tdata, pop: 1'b0};
      echo_cmd = '{push: 1'b0, push_data: req_tdata, pop: 1'b0};
      tx_cmd   = '{push: 1'b0, push_data: req_tdata, pop: 1'b0};
      pend_in  = '0;
      irq_in   = irq_ff;
      if (accept) begin
         unique case (req_tuser)
            ACT_RX_BYTE: begin
               rx_cmd.push        = !rx_full;
               pend_in.rx_dropped = rx_full;
               if (echo_en_ff) begin
                  echo_cmd.push       = !echo_full;
                  // echo queue goes from empty to one deep
                  if (echo_empty) begin
                     irq_in = 1'b1;
                  end
                  pend_in.wake_writer = 1'b1;
               end
            end
            ACT_TX_READY: begin
               if (!echo_empty) begin
                  echo_cmd.pop         = 1'b1;
                  pend_in.tx_valid     = 1'b1;
                  pend_in.tx_from_echo = 1'b1;
               end else if (!tx_empty) begin
                  tx_cmd.pop          = 1'b1;
                  pend_in.tx_valid    = 1'b1;
                  pend_in.wake_writer = 1'b1;
                  irq_in              = 1'b1;
               end else begin
                  irq_in = 1'b0;
               end
            end
            ACT_HOST_WR: begin
               tx_cmd.push            = !tx_full;
               pend_in.write_accepted = !tx_full;
               irq_in                 = 1'b1;
            end
            ACT_HOST_RD: begin
               rx_cmd.pop         = !rx_empty;
               pend_in.read_valid = !rx_empty;
            end
            default: begin
               irq_in = irq_ff;
            end
         endcase
      end
      pend_in.tx_irq_enable = irq_in;
   end

   tteq_fifo u_rx_fifo (
      .clock   (clock),
      .reset   (reset),
      .cmd     (rx_cmd),
      .count   (rx_count),
      .rd_data (rx_rd)
   );

   tteq_fifo u_echo_fifo (
      .clock   (clock),
      .reset   (reset),
      .cmd     (echo_cmd),
      .count   (echo_count),
      .rd_data (echo_rd)
   );

   tteq_fifo u_tx_fifo (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tx_cmd),
      .count   (tx_count),
      .rd_data (tx_rd)
   );

   // Read stage: merge queue read data with the held flags
   always_comb begin
      tx_byte = '0;
      if (pend_ff.tx_valid) begin
         tx_byte = pend_ff.tx_from_echo ? echo_rd : tx_rd;
      end
      rd_byte = pend_ff.read_valid ? rx_rd : '0;
      rsp_data_in = {2'b00, pend_ff.rx_dropped, pend_ff.wake_writer,
                     pend_ff.tx_irq_enable, pend_ff.write_accepted,
                     rd_byte, pend_ff.read_valid, tx_byte, pend_ff.tx_valid};
   end

   always_comb begin
      pend_vld_in = accept ? 1'b1 : (move ? 1'b0 : pend_vld_ff);
      rsp_vld_in  = move ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         echo_en_ff  <= 1'b1;
         irq_ff      <= 1'b0;
         pend_vld_ff <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (csr_we) begin
            echo_en_ff <= csr_wdata;
         end
         irq_ff      <= irq_in;
         pend_vld_ff <= pend_vld_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
      if (move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;

   // A result in the read stage is never lost while the output stalls
   a_pend_holds: assert property (@(posedge clock) disable iff (reset)
      (pend_vld_ff && !out_free) |=> (pend_vld_ff && $stable(pend_ff)))
      else $error("read-stage result lost under stall");

   // Queue fill counts stay within depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (rx_count <= CNT_W'(QUEUE_DEPTH)) && (echo_count <= CNT_W'(QUEUE_DEPTH))
      && (tx_count <= CNT_W'(QUEUE_DEPTH)))
      else $error("queue count out of range");

   // A transmit and a host read never come from the same beat
   a_one_source: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(rsp_data_ff[0] && rsp_data_ff[9]))
      else $error("transmit and read in one response");

   // Nothing is pending or presented straight after reset
   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_vld_ff && !pend_vld_ff))
      else $error("pipeline not idle after reset");

endmodule

`default_nettype wire
